>>> src/bfac_pkg.sv
// ============================================================================
// bfac_pkg
// shared constants, codes, entry type and byte-lane helpers of the cache
// ============================================================================
package bfac_pkg;

    localparam int LINES_DEF    = 16;
    localparam int PORTS        = 4;
    localparam int ADDRESS_BITS = 32;
    localparam int LINE_BYTES   = 8;
    localparam int ADDR_USED    = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int TAG_W        = ADDR_USED - 3;
    localparam int LFSR_W       = 16;
    localparam int CFG_W        = 5;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;

    // request actions
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;

    // result kinds
    localparam logic [2:0] K_RESP   = 3'd0;
    localparam logic [2:0] K_BUSY   = 3'd1;
    localparam logic [2:0] K_SPAN   = 3'd2;
    localparam logic [2:0] K_MEM_RD = 3'd3;
    localparam logic [2:0] K_MEM_WR = 3'd4;
    localparam logic [2:0] K_WB     = 3'd5;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [63:0]      data;
    } entry_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
        logic [63:0] m;
        if (cnt >= 4'd8)
            m = '1;
        else
            m = (64'd1 << {cnt, 3'b000}) - 64'd1;
        return m;
    endfunction

    function automatic logic [63:0] read_bytes(input logic [63:0] line,
                                               input logic [2:0] ofs,
                                               input logic [3:0] cnt);
        return (line >> {ofs, 3'b000}) & byte_mask(cnt);
    endfunction

    function automatic logic [63:0] merge_bytes(input logic [63:0] line,
                                                input logic [2:0] ofs,
                                                input logic [3:0] cnt,
                                                input logic [63:0] wd);
        logic [63:0] m;
        m = byte_mask(cnt) << {ofs, 3'b000};
        return (line & ~m) | ((wd << {ofs, 3'b000}) & m);
    endfunction

endpackage

>>> src/bfac_if.sv
// ============================================================================
// bfac channel interfaces
// request, result and configuration channels with valid/ready beats
// ============================================================================
interface bfac_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  requester;
    logic [31:0] address;
    logic [3:0]  byte_count;
    logic [63:0] write_data;
    logic [63:0] fill_data;

    modport source(output valid, action, requester, address, byte_count, write_data,
                   fill_data, input ready);
    modport sink(input valid, action, requester, address, byte_count, write_data,
                 fill_data, output ready);
endinterface

interface bfac_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [1:0]  port_out;
    logic [31:0] address_out;
    logic [63:0] data_out;
    logic        last;

    modport source(output valid, kind, port_out, address_out, data_out, last,
                   input ready);
    modport sink(input valid, kind, port_out, address_out, data_out, last,
                 output ready);
endinterface

interface bfac_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

>>> src/bfac_mem.sv
// ============================================================================
// bfac_mem
// line store: tag and data per entry, one write and one registered read port
// ============================================================================
module bfac_mem #(
    parameter int LINES = bfac_pkg::LINES_DEF
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(LINES)-1:0]     rd_addr,
    output bfac_pkg::entry_t             rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(LINES)-1:0]     wr_addr,
    input  bfac_pkg::entry_t             wr_data
);
    import bfac_pkg::*;

    entry_t mem [LINES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/bfac_mod.sv
// ============================================================================
// bfac_mod
// restoring remainder unit, one dividend bit per cycle, for victim selection
// ============================================================================
module bfac_mod #(
    parameter int LINES = bfac_pkg::LINES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bfac_pkg::LFSR_W-1:0]    dividend,
    input  logic [$clog2(LINES+1)-1:0]     divisor,
    output logic                           done,
    output logic [$clog2(LINES)-1:0]       rem
);
    import bfac_pkg::*;

    localparam int IW = $clog2(LINES);
    localparam int EW = $clog2(LINES + 1);
    localparam int CW = $clog2(LFSR_W + 1);

    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [LFSR_W-1:0] dvd_reg, dvd_next;
    logic [EW-1:0]     rem_reg, rem_next;
    logic [EW-1:0]     div_reg, div_next;
    logic [EW:0]       trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[LFSR_W-1]};
        if (start)
        begin
            cnt_next = CW'(LFSR_W);
            dvd_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = EW'(trial - {1'b0, div_reg});
            else
                rem_next = EW'(trial);
            dvd_next = {dvd_reg[LFSR_W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[IW-1:0];

endmodule

>>> src/blocking_fully_assoc_cache.sv
// ============================================================================
// blocking_fully_assoc_cache
// blocking fully associative write-allocate cache with lfsr victim choice
// ============================================================================
//
//  channel | dir | beat carries
//  --------+-----+--------------------------------------------------------
//  req     | in  | action, requester, address, byte_count, write/fill data
//  rsp     | out | kind, port_out, address_out, data_out, last
//  cfg     | in  | lines_in_use (5 bits)
//
//  cpu access: the tag scan reads one entry of the line memory per cycle
//    until a tag matches or the occupied lines run out
//  fill: when the store is full, first a 16-step remainder unit for the
//    victim slot, then the victim read and the writeback beat
//  reset: no clearing pass; lines at or above the occupied count are invalid
//  a stalled rsp holds the result register; req is taken only when idle
//
module blocking_fully_assoc_cache #(
    parameter int LINES = bfac_pkg::LINES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bfac_req_if.sink  req,
    bfac_rsp_if.source rsp,
    bfac_cfg_if.sink  cfg
);
    import bfac_pkg::*;

    localparam int IW = $clog2(LINES);
    localparam int EW = $clog2(LINES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_HIT  = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_VWB  = 3'd5;
    localparam logic [2:0] S_INST = 3'd6;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  cfg_reg;
    logic [EW-1:0]     occ_reg, occ_next;
    logic              pend_reg, pend_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [EW-1:0]     scan_idx_reg, scan_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              ov_reg, ov_next;

    // pending request and payload
    logic              r_write_reg, r_write_next;
    logic              r_full_reg, r_full_next;
    logic [1:0]        r_port_reg, r_port_next;
    logic [31:0]       r_addr_reg, r_addr_next;
    logic [3:0]        r_cnt_reg, r_cnt_next;
    logic [63:0]       r_wd_reg, r_wd_next;
    logic [63:0]       fill_reg, fill_next;
    logic [IW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]     slot_reg, slot_next;

    // result register
    logic [2:0]        okind_reg, okind_next;
    logic [1:0]        oport_reg, oport_next;
    logic [31:0]       oaddr_reg, oaddr_next;
    logic [63:0]       odata_reg, odata_next;
    logic              olast_reg, olast_next;

    // memory and remainder unit hookup
    logic              mem_re, mem_we;
    logic [IW-1:0]     mem_raddr, mem_waddr;
    entry_t            mem_rdata, mem_wdata;
    logic              div_start, div_done;
    logic [IW-1:0]     div_rem;

    logic [EW-1:0]     eff;
    logic              out_free, acc, span_bad, port_ok, issue, match;
    logic [2:0]        r_ofs;
    logic [TAG_W-1:0]  r_tag;
    logic [63:0]       inst_data;

    bfac_mem #(.LINES(LINES)) u_mem (
        .clk     (clk),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    bfac_mod #(.LINES(LINES)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lfsr_reg),
        .divisor  (eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    // usable lines: zero counts as one, anything past the store as full size
    always_comb
    begin
        if (cfg_reg == '0)
            eff = EW'(1);
        else if (int'(cfg_reg) > LINES)
            eff = EW'(LINES);
        else
            eff = EW'(cfg_reg);
    end

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign acc       = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign span_bad = (req.byte_count == 4'd0) || (req.byte_count > 4'd8) ||
                      (({2'b00, req.address[2:0]} + {1'b0, req.byte_count}) > 5'd8);
    assign port_ok  = int'(req.requester) < PORTS;

    assign r_ofs = r_addr_reg[2:0];
    assign r_tag = r_addr_reg[ADDR_USED-1:3];

    // scan: one entry read per cycle; the compare works on the registered read data
    assign issue = (state_reg == S_SCAN) && (scan_idx_reg < occ_reg);
    assign match = cmp_vld_reg && (mem_rdata.tag == r_tag);

    // line installed by a fill or acknowledgement
    always_comb
    begin
        if (r_full_reg)
            inst_data = r_wd_reg;
        else if (r_write_reg)
            inst_data = merge_bytes(fill_reg, r_ofs, r_cnt_reg, r_wd_reg);
        else
            inst_data = fill_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        pend_next     = pend_reg;
        lfsr_next     = lfsr_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        slot_next     = slot_reg;
        r_write_next  = r_write_reg;
        r_full_next   = r_full_reg;
        r_port_next   = r_port_reg;
        r_addr_next   = r_addr_reg;
        r_cnt_next    = r_cnt_reg;
        r_wd_next     = r_wd_reg;
        fill_next     = fill_reg;
        ov_next       = ov_reg && !rsp.ready;
        okind_next    = okind_reg;
        oport_next    = oport_reg;
        oaddr_next    = oaddr_reg;
        odata_next    = odata_reg;
        olast_next    = olast_reg;
        mem_re        = 1'b0;
        mem_raddr     = scan_idx_reg[IW-1:0];
        mem_we        = 1'b0;
        mem_waddr     = slot_reg;
        mem_wdata     = '{tag: r_tag, data: inst_data};
        div_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.action)
                        ACT_FILL:
                        begin
                            // stray fills are dropped
                            if (pend_reg)
                            begin
                                fill_next = req.fill_data;
                                if (occ_reg >= eff)
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                                else
                                begin
                                    slot_next  = occ_reg[IW-1:0];
                                    occ_next   = occ_reg + EW'(1);
                                    state_next = S_INST;
                                end
                            end
                        end
                        ACT_READ, ACT_WRITE:
                        begin
                            if (port_ok)
                            begin
                                if (pend_reg || span_bad)
                                begin
                                    ov_next    = 1'b1;
                                    okind_next = pend_reg ? K_BUSY : K_SPAN;
                                    oport_next = req.requester;
                                    oaddr_next = req.address;
                                    odata_next = '0;
                                    olast_next = 1'b1;
                                end
                                else
                                begin
                                    r_write_next  = (req.action == ACT_WRITE);
                                    r_full_next   = (req.action == ACT_WRITE) &&
                                                    (req.address[2:0] == 3'd0) &&
                                                    (req.byte_count == 4'd8);
                                    r_port_next   = req.requester;
                                    r_addr_next   = req.address;
                                    r_cnt_next    = req.byte_count;
                                    r_wd_next     = req.write_data;
                                    scan_idx_next = '0;
                                    state_next    = S_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_re        = issue && !match;
                scan_idx_next = issue ? scan_idx_reg + EW'(1) : scan_idx_reg;
                cmp_vld_next  = issue && !match;
                cmp_idx_next  = scan_idx_reg[IW-1:0];
                if (match)
                begin
                    slot_next  = cmp_idx_reg;
                    state_next = S_HIT;
                end
                else if (!issue)
                begin
                    state_next = S_MISS;
                end
            end
            S_HIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = K_RESP;
                    oport_next = r_port_reg;
                    oaddr_next = r_addr_reg;
                    olast_next = 1'b1;
                    if (r_write_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = '{tag: r_tag,
                                       data: merge_bytes(mem_rdata.data, r_ofs,
                                                         r_cnt_reg, r_wd_reg)};
                        odata_next = '0;
                    end
                    else
                    begin
                        odata_next = read_bytes(mem_rdata.data, r_ofs, r_cnt_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (out_free)
                begin
                    pend_next  = 1'b1;
                    ov_next    = 1'b1;
                    okind_next = r_full_reg ? K_MEM_WR : K_MEM_RD;
                    oport_next = '0;
                    oaddr_next = 32'({r_tag, 3'b000});
                    odata_next = r_full_reg ? r_wd_reg : 64'd0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = div_rem;
                    slot_next  = div_rem;
                    state_next = S_VWB;
                end
            end
            S_VWB:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = K_WB;
                    oport_next = '0;
                    oaddr_next = 32'({mem_rdata.tag, 3'b000});
                    odata_next = mem_rdata.data;
                    olast_next = 1'b0;
                    lfsr_next  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS)
                                             : (lfsr_reg >> 1);
                    state_next = S_INST;
                end
            end
            S_INST:
            begin
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    pend_next  = 1'b0;
                    ov_next    = 1'b1;
                    okind_next = K_RESP;
                    oport_next = r_port_reg;
                    oaddr_next = r_addr_reg;
                    odata_next = (!r_full_reg && !r_write_reg)
                                 ? read_bytes(fill_reg, r_ofs, r_cnt_reg) : 64'd0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cfg_reg      <= CFG_RESET;
            occ_reg      <= '0;
            pend_reg     <= 1'b0;
            lfsr_reg     <= LFSR_SEED;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            pend_reg     <= pend_next;
            lfsr_reg     <= lfsr_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            ov_reg       <= ov_next;
            if (cfg.valid)
            begin
                cfg_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_write_reg <= r_write_next;
        r_full_reg  <= r_full_next;
        r_port_reg  <= r_port_next;
        r_addr_reg  <= r_addr_next;
        r_cnt_reg   <= r_cnt_next;
        r_wd_reg    <= r_wd_next;
        fill_reg    <= fill_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        okind_reg   <= okind_next;
        oport_reg   <= oport_next;
        oaddr_reg   <= oaddr_next;
        odata_reg   <= odata_next;
        olast_reg   <= olast_next;
    end

    assign rsp.valid       = ov_reg;
    assign rsp.kind        = okind_reg;
    assign rsp.port_out    = oport_reg;
    assign rsp.address_out = oaddr_reg;
    assign rsp.data_out    = odata_reg;
    assign rsp.last        = olast_reg;

`ifndef SYNTHESIS
    // occupied count never passes the store size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= EW'(LINES))
        else $error("occupied count beyond store size");

    // every line write lands inside the valid prefix
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (EW'(mem_waddr) < occ_reg))
        else $error("line write outside occupied lines");

    // victim slot lies below the usable line count
    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (EW'(div_rem) < eff))
        else $error("victim slot out of range");

    // a memory line request is only shown while the miss is pending
    a_miss_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.kind == K_MEM_RD || rsp.kind == K_MEM_WR)) |-> pend_reg)
        else $error("line request without pending miss");

    // no lookup runs while a miss is outstanding
    a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !pend_reg)
        else $error("tag scan during pending miss");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// self-checking bench for the blocking fully associative cache: a queue-fed
// request driver with bursty gaps, a stalling result sink, a predictor
// of lines, pending miss and victim lfsr, and phases that step
// through several lines_in_use settings
// ============================================================================
module testbench;
    import bfac_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int DRAIN_CYCLES = 64;   // settle time after the last beat, for scan + eviction
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [1:0]  action;
        logic [1:0]  requester;
        logic [31:0] address;
        logic [3:0]  byte_count;
        logic [63:0] write_data;
        logic [63:0] fill_data;
    } cache_req_t;

    typedef struct {
        logic [2:0]  kind;
        logic [1:0]  port_out;
        logic [31:0] address_out;
        logic [63:0] data_out;
        logic        last;
    } cache_rsp_t;

    logic clk;
    logic rst_n;

    bfac_req_if req_ch ();
    bfac_rsp_if rsp_ch ();
    bfac_cfg_if cfg_ch ();

    blocking_fully_assoc_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // stimulus waiting to be driven, and results the cache owes us
    cache_req_t req_queue[$];
    cache_rsp_t owed_rsp[$];
    int         errors;
    int         cycles;
    logic       req_taken;

    // ------------------------------------------------------------------------
    // shadow copy of the cache
    // ------------------------------------------------------------------------
    logic [28:0] sh_tag   [LINES_DEF];
    logic        sh_valid [LINES_DEF];
    logic [63:0] sh_data  [LINES_DEF];
    int          sh_occupied;
    logic        sh_pending;
    logic [1:0]  sh_port;
    logic        sh_is_write;
    logic        sh_full_line;
    logic [31:0] sh_addr;
    logic [3:0]  sh_count;
    logic [63:0] sh_wdata;
    logic [15:0] sh_lfsr;
    logic [4:0]  sh_lines_cfg;

    // byte lanes covered by an access of cnt bytes at line offset ofs
    function automatic logic [63:0] lane_mask(input logic [3:0] cnt, input logic [2:0] ofs);
        logic [63:0] m;
        m = (cnt >= 4'd8) ? {64{1'b1}} : ((64'd1 << (8 * cnt)) - 64'd1);
        return m << (8 * ofs);
    endfunction

    function automatic logic [63:0] extract(input logic [63:0] line, input logic [31:0] a,
                                            input logic [3:0] cnt);
        return (line & lane_mask(cnt, a[2:0])) >> (8 * a[2:0]);
    endfunction

    function automatic logic [63:0] splice(input logic [63:0] line, input logic [31:0] a,
                                           input logic [3:0] cnt, input logic [63:0] wd);
        logic [63:0] m;
        m = lane_mask(cnt, a[2:0]);
        return (line & ~m) | ((wd << (8 * a[2:0])) & m);
    endfunction

    task automatic owe(input logic [2:0] k, input logic [1:0] p, input logic [31:0] a,
                       input logic [63:0] d, input logic l);
        cache_rsp_t r;
        r.kind = k;
        r.port_out = p;
        r.address_out = a;
        r.data_out = d;
        r.last = l;
        owed_rsp.push_back(r);
    endtask

    // fill or acknowledgement completing the pending miss
    task automatic complete_miss(input logic [63:0] fill);
        int          usable;
        int          slot;
        logic [63:0] line;
        logic [63:0] answer;
        usable = (sh_lines_cfg == 0) ? 1 : ((sh_lines_cfg > LINES_DEF) ? LINES_DEF
                                                                        : sh_lines_cfg);
        line = sh_full_line ? sh_wdata : fill;
        answer = '0;
        if (sh_occupied >= usable)
        begin
            // store full: write back a victim picked from the lfsr
            slot = sh_lfsr % usable;
            owe(K_WB, 2'd0, {sh_tag[slot], 3'b000}, sh_data[slot], 1'b0);
            sh_lfsr = sh_lfsr[0] ? ((sh_lfsr >> 1) ^ LFSR_TAPS) : (sh_lfsr >> 1);
        end
        else
        begin
            slot = sh_occupied;
            sh_occupied++;
        end
        sh_tag[slot] = sh_addr[31:3];
        sh_valid[slot] = 1'b1;
        if (!sh_full_line)
        begin
            if (sh_is_write)
                line = splice(line, sh_addr, sh_count, sh_wdata);
            else
                answer = extract(line, sh_addr, sh_count);
        end
        sh_data[slot] = line;
        owe(K_RESP, sh_port, sh_addr, answer, 1'b1);
        sh_pending = 1'b0;
        sh_port = '0;
        sh_is_write = 1'b0;
        sh_full_line = 1'b0;
        sh_addr = '0;
        sh_count = '0;
        sh_wdata = '0;
    endtask

    task automatic predict_cache(input cache_req_t it);
        int hit;
        hit = -1;
        if (it.action == ACT_FILL)
        begin
            if (sh_pending)
                complete_miss(it.fill_data);
        end
        else if (it.action == ACT_READ || it.action == ACT_WRITE)
        begin
            if (sh_pending)
                owe(K_BUSY, it.requester, it.address, '0, 1'b1);
            else if (it.byte_count == 0 || it.byte_count > 8 ||
                     {1'b0, it.address[2:0]} + {1'b0, it.byte_count} > 5'd8)
                owe(K_SPAN, it.requester, it.address, '0, 1'b1);
            else
            begin
                for (int i = 0; i < LINES_DEF; i++)
                    if (hit < 0 && sh_valid[i] && sh_tag[i] == it.address[31:3])
                        hit = i;
                if (hit >= 0)
                begin
                    if (it.action == ACT_WRITE)
                    begin
                        sh_data[hit] = splice(sh_data[hit], it.address, it.byte_count,
                                              it.write_data);
                        owe(K_RESP, it.requester, it.address, '0, 1'b1);
                    end
                    else
                        owe(K_RESP, it.requester, it.address,
                            extract(sh_data[hit], it.address, it.byte_count), 1'b1);
                end
                else
                begin
                    sh_pending = 1'b1;
                    sh_port = it.requester;
                    sh_is_write = (it.action == ACT_WRITE);
                    sh_full_line = sh_is_write && it.address[2:0] == 3'd0 &&
                                   it.byte_count == 4'd8;
                    sh_addr = it.address;
                    sh_count = it.byte_count;
                    sh_wdata = sh_is_write ? it.write_data : '0;
                    if (sh_full_line)
                        owe(K_MEM_WR, 2'd0, {it.address[31:3], 3'b000}, it.write_data,
                            1'b1);
                    else
                        owe(K_MEM_RD, 2'd0, {it.address[31:3], 3'b000}, '0, 1'b1);
                end
            end
        end
        // action 3 is ignored
    endtask

    task automatic report(input string what);
        $display("mismatch @%0d: %s", cycles, what);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request driver: bursts of beats with random gaps, changes at falling edge
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk)
        req_taken <= req_ch.valid && req_ch.ready;

    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (req_queue.size() > 0)
            begin
                cache_req_t it;
                it = req_queue.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.action <= it.action;
                req_ch.requester <= it.requester;
                req_ch.address <= it.address;
                req_ch.byte_count <= it.byte_count;
                req_ch.write_data <= it.write_data;
                req_ch.fill_data <= it.fill_data;
                if (burst_left <= 1)
                begin
                    // long pauses now and then, otherwise short ones or none
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                             : $urandom_range(0, 3);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: stall pattern rotates through a random word, with
    // stretches of no stalling in between
    // ------------------------------------------------------------------------
    logic [15:0] stall_pattern;
    int          stall_window;

    always @(negedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_window <= $urandom_range(20, 120);
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end
        else
        begin
            stall_window <= stall_window - 1;
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        end
        rsp_ch.ready <= stall_pattern[0];
    end

    // ------------------------------------------------------------------------
    // monitor: predict on each accepted request, check each result beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            cache_req_t it;
            it.action = req_ch.action;
            it.requester = req_ch.requester;
            it.address = req_ch.address;
            it.byte_count = req_ch.byte_count;
            it.write_data = req_ch.write_data;
            it.fill_data = req_ch.fill_data;
            predict_cache(it);
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            cache_rsp_t want;
            if (owed_rsp.size() == 0)
                report($sformatf("unexpected beat kind %0d addr %h", rsp_ch.kind,
                                 rsp_ch.address_out));
            else
            begin
                want = owed_rsp.pop_front();
                if (rsp_ch.kind !== want.kind || rsp_ch.port_out !== want.port_out ||
                    rsp_ch.address_out !== want.address_out ||
                    rsp_ch.data_out !== want.data_out || rsp_ch.last !== want.last)
                    report($sformatf("got k%0d p%0d a%h d%h l%0d want k%0d p%0d a%h d%h l%0d",
                                     rsp_ch.kind, rsp_ch.port_out, rsp_ch.address_out,
                                     rsp_ch.data_out, rsp_ch.last, want.kind,
                                     want.port_out, want.address_out, want.data_out,
                                     want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    logic [28:0] tag_pool[24];

    task automatic add_item(input logic [1:0] act, input logic [1:0] who,
                            input logic [31:0] a, input logic [3:0] cnt,
                            input logic [63:0] wd, input logic [63:0] fd);
        cache_req_t it;
        it.action = act;
        it.requester = who;
        it.address = a;
        it.byte_count = cnt;
        it.write_data = wd;
        it.fill_data = fd;
        req_queue.push_back(it);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // wait until the driver is empty and every owed beat has come
    task automatic drain();
        do
            @(posedge clk);
        while (req_queue.size() > 0 || req_ch.valid || owed_rsp.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_lines_in_use(input logic [4:0] v);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sh_lines_cfg = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one well-formed access, mostly followed by its fill
    task automatic add_access();
        logic [2:0]  ofs;
        logic [3:0]  cnt;
        logic [31:0] a;
        ofs = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
        cnt = (ofs == 0 && $urandom_range(0, 2) == 0) ? 4'd8
                                                       : 4'($urandom_range(1, 8 - ofs));
        a = {tag_pool[$urandom_range(0, 23)], ofs};
        add_item(2'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), a, cnt, rand64(),
                 rand64());
        if ($urandom_range(0, 99) < 85)
            add_item(ACT_FILL, 2'($urandom_range(0, 3)), $urandom,
                     4'($urandom_range(0, 15)), rand64(), rand64());
    endtask

    task automatic add_noise();
        add_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                 ($urandom_range(0, 1) == 0) ? $urandom : {tag_pool[$urandom_range(0, 23)],
                                                           3'($urandom_range(0, 7))},
                 4'($urandom_range(0, 15)), rand64(), rand64());
    endtask

    logic [4:0] cfg_plan[8];

    initial
    begin
        errors = 0;
        cycles = 0;
        burst_left = 1;
        gap_left = 0;
        stall_window = 0;
        stall_pattern = 16'hFFFF;
        req_taken = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_READ;
        req_ch.requester = '0;
        req_ch.address = '0;
        req_ch.byte_count = '0;
        req_ch.write_data = '0;
        req_ch.fill_data = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        for (int i = 0; i < LINES_DEF; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_tag[i] = '0;
            sh_data[i] = '0;
        end
        sh_occupied = 0;
        sh_pending = 1'b0;
        sh_port = '0;
        sh_is_write = 1'b0;
        sh_full_line = 1'b0;
        sh_addr = '0;
        sh_count = '0;
        sh_wdata = '0;
        sh_lfsr = LFSR_SEED;
        sh_lines_cfg = CFG_RESET;
        for (int i = 0; i < 24; i++)
            tag_pool[i] = 29'($urandom);
        cfg_plan = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd4, 5'd31, 5'd3, 5'd16};

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: miss and fill, hits, full-line write, busy, span, ignored items
        add_item(ACT_READ, 2'd0, 32'h0000_0000, 4'd8, '0, '0);
        add_item(ACT_READ, 2'd3, 32'h0000_0004, 4'd4, '0, '0);          // busy reject
        add_item(ACT_FILL, 2'd0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(ACT_READ, 2'd1, 32'h0000_0007, 4'd1, '0, '0);          // hit
        add_item(ACT_WRITE, 2'd2, 32'h0000_0002, 4'd3, 64'h0123_4567_89AB_CDEF, '0);
        add_item(ACT_READ, 2'd3, 32'h0000_0000, 4'd8, '0, '0);
        add_item(ACT_WRITE, 2'd3, 32'hFFFF_FFF8, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        add_item(ACT_FILL, 2'd0, '0, '0, '0, 64'h5555_AAAA_5555_AAAA);  // ack
        add_item(ACT_READ, 2'd0, 32'hFFFF_FFFF, 4'd1, '0, '0);
        add_item(ACT_WRITE, 2'd1, 32'h0000_1235, 4'd2, 64'hA5A5, '0);   // write miss
        add_item(ACT_FILL, 2'd0, '0, '0, '0, 64'h0F0F_0F0F_F0F0_F0F0);
        add_item(ACT_READ, 2'd1, 32'h0000_1230, 4'd8, '0, '0);
        add_item(ACT_READ, 2'd0, 32'h0000_0010, 4'd0, '0, '0);          // span: zero count
        add_item(ACT_WRITE, 2'd2, 32'h0000_0010, 4'd15, '0, '0);        // span: too many
        add_item(ACT_READ, 2'd1, 32'h0000_0015, 4'd4, '0, '0);          // span: crossing
        add_item(ACT_FILL, 2'd2, 32'hFFFF_FFFF, 4'd15, rand64(), rand64()); // stray fill
        add_item(2'd3, 2'd3, 32'hFFFF_FFFF, 4'd8, rand64(), rand64());  // unused action
        add_item(ACT_READ, 2'd2, 32'h0000_0000, 4'd8, '0, '0);
        drain();

        // random phases across capacity settings, idle between them
        foreach (cfg_plan[p])
        begin
            write_lines_in_use(cfg_plan[p]);
            for (int n = 0; n < 32; n++)
                if ($urandom_range(0, 99) < 80)
                    add_access();
                else
                    add_noise();
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
